// ----- sv/cnfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the CNF clause simplifier.
// Depends on nothing; every file but cnfs_ram imports it.
package cnfs_pkg;

    localparam int LIT_W  = 12;
    localparam int KEPT_W = 17;

    // Input item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_ASSUME = 2'd1;
    localparam logic [1:0] KIND_CLAUSE = 2'd2;
    localparam logic [1:0] KIND_EOF    = 2'd3;

    // Result kinds
    localparam logic [1:0] RK_KEEP    = 2'd0;
    localparam logic [1:0] RK_EMPTY   = 2'd1;
    localparam logic [1:0] RK_VERDICT = 2'd2;

    // Verdict codes
    localparam logic [1:0] V_UNSAT = 2'd0;
    localparam logic [1:0] V_SAT   = 2'd1;
    localparam logic [1:0] V_UNDEC = 2'd2;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [LIT_W-1:0] literal;
        logic                    clause_end;
    } item_t;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic signed [LIT_W-1:0] out_literal;
        logic                    last;
        logic [1:0]              verdict;
        logic [KEPT_W-1:0]       kept_clauses;
        logic                    overflow;
    } result_t;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        OP_KEEP = 2'd0,
        OP_SAT  = 2'd1,
        OP_SKIP = 2'd2,
        OP_EOF  = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [LIT_W-1:0] literal;
        logic             clause_end;
    } cmd_t;

endpackage : cnfs_pkg
`default_nettype wire

// ----- sv/cnfs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cnfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : cnfs_ram
`default_nettype wire

// ----- sv/cnfs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Small command FIFO between the classifying front and the executing back.
// Depends on cnfs_pkg for the command type.
module cnfs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire cnfs_pkg::cmd_t push_cmd,
    output logic                full,
    output logic                valid,
    output cnfs_pkg::cmd_t      cmd,
    input  wire logic           pop
);
    import cnfs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign valid   = (count_reg != '0);
    assign cmd     = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule : cnfs_queue
`default_nettype wire

// ----- sv/cnfs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts items, keeps the assumption bitmaps, classifies literals.
// Depends on cnfs_pkg and cnfs_ram; feeds cnfs_queue.
module cnfs_front #(
    parameter int NUM_VARS = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire cnfs_pkg::item_t item,
    output logic                 push,
    output cnfs_pkg::cmd_t       push_cmd,
    input  wire logic            q_full
);
    import cnfs_pkg::*;

    localparam int AW = $clog2(NUM_VARS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(NUM_VARS - 1);

    function automatic logic [LIT_W-1:0] lit_mag(input logic [LIT_W-1:0] raw);
        return raw[LIT_W-1] ? (LIT_W'(0) - raw) : raw;
    endfunction

    logic          s1_valid_reg, s1_valid_next;
    item_t         s1_item_reg;
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic             accept;
    logic [LIT_W-1:0] in_raw, in_var;
    logic             in_neg, in_ok;
    logic [AW-1:0]    in_addr;
    logic             add_lit;

    logic             t_we, f_we, ram_wdata;
    logic [AW-1:0]    ram_waddr;
    logic             t_bit, f_bit;

    logic [LIT_W-1:0] s1_raw, s1_var;
    logic             s1_neg, s1_ok, same_set, opp_set;
    logic             needs_push, s1_drain;
    cmd_t             cmd_c;

    // Incoming item: bitmap access happens at the accept edge
    assign in_raw  = $unsigned(item.literal);
    assign in_neg  = in_raw[LIT_W-1];
    assign in_var  = lit_mag(in_raw);
    assign in_ok   = (in_var != '0) && (32'(in_var) <= 32'(NUM_VARS));
    assign in_addr = AW'(in_var - LIT_W'(1));

    assign accept  = item_valid && !item_stall;
    assign add_lit = accept && (item.kind == KIND_ASSUME) && in_ok;

    // Clearing sweep owns the write port; reads only come with accepted items
    assign ram_waddr = clr_active_reg ? clr_addr_reg : in_addr;
    assign ram_wdata = !clr_active_reg;
    assign t_we      = clr_active_reg || (add_lit && !in_neg);
    assign f_we      = clr_active_reg || (add_lit && in_neg);

    cnfs_ram #(
        .WIDTH (1),
        .DEPTH (NUM_VARS)
    ) u_true_map (
        .clk   (clk),
        .we    (t_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (t_bit)
    );

    cnfs_ram #(
        .WIDTH (1),
        .DEPTH (NUM_VARS)
    ) u_false_map (
        .clk   (clk),
        .we    (f_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (f_bit)
    );

    // Classify the held item against the bitmap bits read for it
    assign s1_raw   = $unsigned(s1_item_reg.literal);
    assign s1_neg   = s1_raw[LIT_W-1];
    assign s1_var   = lit_mag(s1_raw);
    assign s1_ok    = (s1_var != '0) && (32'(s1_var) <= 32'(NUM_VARS));
    assign same_set = s1_ok && (s1_neg ? f_bit : t_bit);
    assign opp_set  = s1_ok && (s1_neg ? t_bit : f_bit);

    always_comb
    begin
        cmd_c.literal    = s1_raw;
        cmd_c.clause_end = s1_item_reg.clause_end;
        cmd_c.op         = OP_SKIP;
        needs_push       = 1'b0;
        unique case (s1_item_reg.kind)
            KIND_CLAUSE:
            begin
                if (s1_var == '0)
                begin
                    cmd_c.op = OP_SKIP;
                end
                else if (same_set)
                begin
                    cmd_c.op = OP_SAT;
                end
                else if (opp_set)
                begin
                    cmd_c.op = OP_SKIP;
                end
                else
                begin
                    cmd_c.op = OP_KEEP;
                end
                needs_push = (cmd_c.op != OP_SKIP) || s1_item_reg.clause_end;
            end
            KIND_EOF:
            begin
                cmd_c.op   = OP_EOF;
                needs_push = 1'b1;
            end
            default:
            begin
                needs_push = 1'b0;
            end
        endcase
    end

    assign s1_drain   = !needs_push || !q_full;
    assign push       = s1_valid_reg && needs_push && !q_full;
    assign push_cmd   = cmd_c;
    assign item_stall = clr_active_reg || (s1_valid_reg && !s1_drain);

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_drain)
        begin
            s1_valid_next = 1'b0;
        end
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == ADDR_LAST)
            begin
                clr_active_next = 1'b0;
                clr_addr_next   = '0;
            end
        end
        else if (accept && (item.kind == KIND_CLEAR))
        begin
            clr_active_next = 1'b1;
            clr_addr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
    end

endmodule : cnfs_front
`default_nettype wire

// ----- sv/cnfs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Back end: tracks the clause in progress, buffers survivors, emits results.
// Depends on cnfs_pkg and cnfs_ram; drains cnfs_queue.
module cnfs_back #(
    parameter int MAX_CLAUSE_LITS = 16,
    parameter int MAX_CLAUSES     = 65536
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire cnfs_pkg::cmd_t cmd,
    output logic                pop,
    output logic                result_valid,
    input  wire logic           result_stall,
    output cnfs_pkg::result_t   result
);
    import cnfs_pkg::*;

    localparam int FW  = $clog2(MAX_CLAUSE_LITS + 1);
    localparam int BAW = $clog2(MAX_CLAUSE_LITS);
    localparam int KW  = $clog2(MAX_CLAUSES + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_CLAUSE_LITS);
    localparam logic [KW-1:0] KEPT_MAX = KW'(MAX_CLAUSES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_WR   = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          sat_reg, sat_next;
    logic          unsat_reg, unsat_next;
    logic          ovf_reg, ovf_next;
    logic [KW-1:0] kept_reg, kept_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] len_reg, len_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;
    logic          out_load;

    logic             out_free, is_keep, has_room, sat_now, ovf_after, run_last;
    logic [FW-1:0]    fill_after;
    logic             buf_we, buf_re;
    logic [LIT_W-1:0] buf_rdata;

    assign out_free   = !out_valid_reg || !result_stall;
    assign pop        = (state_reg == ST_IDLE) && q_valid && out_free;
    assign is_keep    = !sat_reg && (cmd.op == OP_KEEP);
    assign has_room   = fill_reg < FILL_MAX;
    assign sat_now    = sat_reg || (cmd.op == OP_SAT);
    assign fill_after = fill_reg + FW'(is_keep && has_room);
    assign ovf_after  = ovf_reg || (is_keep && !has_room);
    assign buf_we     = pop && is_keep && has_room;
    assign buf_re     = (state_reg == ST_RD);
    assign run_last   = (idx_reg == len_reg - FW'(1));

    cnfs_ram #(
        .WIDTH (LIT_W),
        .DEPTH (MAX_CLAUSE_LITS)
    ) u_clause_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (fill_reg[BAW-1:0]),
        .wdata (cmd.literal),
        .re    (buf_re),
        .raddr (idx_reg[BAW-1:0]),
        .rdata (buf_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        sat_next   = sat_reg;
        unsat_next = unsat_reg;
        ovf_next   = ovf_reg;
        kept_next  = kept_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        out_load   = 1'b0;

        out_next.result_kind  = RK_KEEP;
        out_next.out_literal  = '0;
        out_next.last         = 1'b0;
        out_next.verdict      = V_UNSAT;
        out_next.kept_clauses = '0;
        out_next.overflow     = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (cmd.op == OP_EOF)
                    begin
                        // Verdict carries the flags as they stand, then the formula resets
                        out_load              = 1'b1;
                        out_next.result_kind  = RK_VERDICT;
                        out_next.verdict      = unsat_reg ? V_UNSAT :
                                                ((kept_reg == '0) ? V_SAT : V_UNDEC);
                        out_next.kept_clauses = KEPT_W'(kept_reg);
                        fill_next  = '0;
                        sat_next   = 1'b0;
                        unsat_next = 1'b0;
                        ovf_next   = 1'b0;
                        kept_next  = '0;
                    end
                    else if (cmd.clause_end)
                    begin
                        fill_next = '0;
                        sat_next  = 1'b0;
                        ovf_next  = ovf_after;
                        if (!sat_now)
                        begin
                            if (fill_after == '0)
                            begin
                                out_load             = 1'b1;
                                out_next.result_kind = RK_EMPTY;
                                out_next.overflow    = ovf_after;
                                unsat_next           = 1'b1;
                            end
                            else
                            begin
                                len_next   = fill_after;
                                idx_next   = '0;
                                state_next = ST_RD;
                                if (kept_reg != KEPT_MAX)
                                begin
                                    kept_next = kept_reg + KW'(1);
                                end
                            end
                        end
                    end
                    else
                    begin
                        fill_next = fill_after;
                        sat_next  = sat_now;
                        ovf_next  = ovf_after;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    out_load             = 1'b1;
                    out_next.result_kind = RK_KEEP;
                    out_next.out_literal = $signed(buf_rdata);
                    out_next.last        = run_last;
                    idx_next             = idx_reg + FW'(1);
                    state_next           = run_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            sat_reg       <= 1'b0;
            unsat_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            kept_reg      <= '0;
            idx_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sat_reg       <= sat_next;
            unsat_reg     <= unsat_next;
            ovf_reg       <= ovf_next;
            kept_reg      <= kept_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule : cnfs_back
`default_nettype wire

// ----- sv/cnf_clause_simplifier_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// CNF clause simplifier under a partial assignment.
//
// Input channel (item, item_valid, item_stall): a beat is taken when item_valid
// is high and item_stall low. Kinds: clear assumptions, add assumption literal,
// clause literal (with clause_end on the last literal), end of formula.
// Output channel (result, result_valid, result_stall): kept literals of each
// surviving clause as one run (last on the final one), an empty-clause report,
// and at end of formula a verdict with the kept-clause count.
//
// Throughput: the front takes one beat per cycle while item_stall is low; each
// literal gets one lookup in the two assumption bitmap RAMs. The back emits each
// literal of a kept clause through a read state then a write state (registered
// read of the clause buffer RAM), and other commands at one per cycle while its
// output register is free; a four-entry queue decouples the two. A verdict or
// empty-clause beat reaches result through the front's item register, the queue
// and the output register. Reset: the bitmaps are swept to zero while item_stall
// stays high; a clear-assumptions beat starts the same sweep.
// A stalled result holds; the queue then fills and item_stall rises.
module cnf_clause_simplifier_core #(
    parameter int NUM_VARS        = 1024,
    parameter int MAX_CLAUSE_LITS = 16,
    parameter int MAX_CLAUSES     = 65536
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire cnfs_pkg::item_t item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output cnfs_pkg::result_t    result
);
    import cnfs_pkg::*;

    logic push, q_full, q_valid, pop;
    cmd_t push_cmd, q_cmd;

    cnfs_front #(
        .NUM_VARS (NUM_VARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    cnfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .cmd      (q_cmd),
        .pop      (pop)
    );

    cnfs_back #(
        .MAX_CLAUSE_LITS (MAX_CLAUSE_LITS),
        .MAX_CLAUSES     (MAX_CLAUSES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .cmd          (q_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule : cnf_clause_simplifier_core
`default_nettype wire

// ----- sv/cnfs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for cnf_clause_simplifier_core, attached by bind.
// Depends on cnfs_pkg for the result type and codes.
module cnfs_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_stall,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire cnfs_pkg::result_t result
);
    import cnfs_pkg::*;

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Non-literal beats carry no literal and no run mark
    a_nonlit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind != RK_KEEP)
            |-> (result.out_literal == '0) && !result.last)
        else $error("non-literal result carries literal data");

    // A sat verdict means no clause was kept
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == RK_VERDICT) && (result.verdict == V_SAT)
            |-> (result.kept_clauses == '0))
        else $error("sat verdict with kept clauses");

    // Bitmap sweep blocks input right after reset
    a_sweep: assert property (@(posedge clk)
        $rose(rst_n) |-> item_stall)
        else $error("input taken during reset sweep");

endmodule : cnfs_checker

bind cnf_clause_simplifier_core cnfs_checker u_cnfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

// ----- sim/tb_cnf_clause_simplifier_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for cnf_clause_simplifier_core: directed formulas, then random ones.
// A scoreboard class predicts each result beat and checks the block's output in order.
// Depends on cnfs_pkg and the core RTL only.
module tb_cnf_clause_simplifier_core;
    import cnfs_pkg::*;

    localparam int NUM_VARS    = 1024;
    localparam int MAX_LITS    = 16;
    localparam int MAX_CLAUSES = 65536;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_GOAL   = 298;
    localparam int CALM_AFTER  = 250;

    class clause_scoreboard;
        bit               true_set[NUM_VARS];
        bit               false_set[NUM_VARS];
        logic [LIT_W-1:0] held_lits[MAX_LITS];
        int unsigned      held_n;
        bit               satisfied;
        bit               unsat;
        bit               ovf;
        int unsigned      kept;
        result_t          simplified_q[$];
        int unsigned      errors;

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void push(logic [1:0] rk, logic [LIT_W-1:0] lit, logic last_flag,
                           logic [1:0] vd, logic [KEPT_W-1:0] kc);
            result_t r;
            r.result_kind  = rk;
            r.out_literal  = lit;
            r.last         = last_flag;
            r.verdict      = vd;
            r.kept_clauses = kc;
            r.overflow     = ovf;
            simplified_q   = {simplified_q, r};
        endfunction

        // Run one accepted beat through the simplifier and queue what it emits.
        function void note_item(item_t it);
            logic [LIT_W-1:0] raw;
            bit               neg;
            int unsigned      vnum;
            bit               in_range;
            bit               same_hit;
            bit               opp_hit;
            logic [1:0]       vd;
            raw  = it.literal;
            neg  = raw[LIT_W-1];
            vnum = 32'(raw);
            if (neg)
                vnum = 4096 - vnum;
            in_range = (vnum >= 1) && (vnum <= NUM_VARS);
            case (it.kind)
                KIND_CLEAR:
                begin
                    foreach (true_set[i])
                    begin
                        true_set[i]  = 1'b0;
                        false_set[i] = 1'b0;
                    end
                end
                KIND_ASSUME:
                begin
                    if (in_range)
                    begin
                        if (neg)
                            false_set[vnum-1] = 1'b1;
                        else
                            true_set[vnum-1] = 1'b1;
                    end
                end
                KIND_EOF:
                begin
                    vd = unsat ? V_UNSAT : ((kept == 0) ? V_SAT : V_UNDEC);
                    push(RK_VERDICT, '0, 1'b0, vd, kept[KEPT_W-1:0]);
                    held_n    = 0;
                    satisfied = 1'b0;
                    unsat     = 1'b0;
                    kept      = 0;
                    ovf       = 1'b0;
                end
                KIND_CLAUSE:
                begin
                    if (!satisfied && vnum != 0)
                    begin
                        same_hit = 1'b0;
                        opp_hit  = 1'b0;
                        if (in_range)
                        begin
                            same_hit = neg ? false_set[vnum-1] : true_set[vnum-1];
                            opp_hit  = neg ? true_set[vnum-1] : false_set[vnum-1];
                        end
                        if (same_hit)
                            satisfied = 1'b1;
                        else if (!opp_hit)
                        begin
                            if (held_n < MAX_LITS)
                            begin
                                held_lits[held_n] = raw;
                                held_n++;
                            end
                            else
                                ovf = 1'b1;
                        end
                    end
                    if (it.clause_end)
                    begin
                        if (!satisfied)
                        begin
                            if (held_n == 0)
                            begin
                                unsat = 1'b1;
                                push(RK_EMPTY, '0, 1'b0, V_UNSAT, '0);
                            end
                            else
                            begin
                                for (int i = 0; i < held_n; i++)
                                    push(RK_KEEP, held_lits[i], i == held_n - 1, V_UNSAT, '0);
                                if (kept < MAX_CLAUSES)
                                    kept++;
                            end
                        end
                        held_n    = 0;
                        satisfied = 1'b0;
                    end
                end
            endcase
        endfunction

        task check_result(result_t r);
            result_t e;
            if (simplified_q.size() == 0)
            begin
                report($sformatf("unexpected beat %h", r));
                return;
            end
            e = simplified_q.pop_front();
            if (r.result_kind !== e.result_kind)
                report($sformatf("result_kind %0d, want %0d", r.result_kind, e.result_kind));
            if (r.out_literal !== e.out_literal)
                report($sformatf("out_literal %0d, want %0d", r.out_literal, e.out_literal));
            if (r.last !== e.last)
                report($sformatf("last %b, want %b", r.last, e.last));
            if (r.verdict !== e.verdict)
                report($sformatf("verdict %0d, want %0d", r.verdict, e.verdict));
            if (r.kept_clauses !== e.kept_clauses)
                report($sformatf("kept_clauses %0d, want %0d", r.kept_clauses, e.kept_clauses));
            if (r.overflow !== e.overflow)
                report($sformatf("overflow %b, want %b", r.overflow, e.overflow));
        endtask
    endclass

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    clause_scoreboard sb;
    int unsigned      sent         = 0;
    int unsigned      cycles       = 0;
    int unsigned      stall_left   = 0;
    bit               idle_on      = 1'b0;
    bit               calm         = 1'b0;

    cnf_clause_simplifier_core #(
        .NUM_VARS       (NUM_VARS),
        .MAX_CLAUSE_LITS(MAX_LITS),
        .MAX_CLAUSES    (MAX_CLAUSES)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver back-pressure in short bursts.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else if (rst_n && idle_on && !calm && $urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= $urandom_range(0, 2);
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic item_t make_item(logic [1:0] k, int lit, logic e);
        item_t it;
        it.kind       = k;
        it.literal    = lit[LIT_W-1:0];
        it.clause_end = e;
        return it;
    endfunction

    // Mostly small in-range variables, sometimes any 12-bit pattern.
    function automatic int pick_lit(int unsigned nv);
        int v;
        if ($urandom_range(0, 99) < 12)
            return int'($urandom_range(0, 4095));
        v = int'($urandom_range(1, nv));
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    task automatic pause_input(int unsigned n);
        item_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(item_t it);
        if (idle_on && !calm && $urandom_range(0, 4) == 0)
            pause_input($urandom_range(1, 3));
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        sent++;
    endtask

    // Hold the sender until every predicted beat has come out.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.simplified_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_formula();
        int unsigned nv;
        int unsigned n_asm;
        int unsigned n_cl;
        int unsigned len;
        bit          close_it;
        nv      = $urandom_range(3, 24);
        idle_on = ($urandom_range(0, 3) != 0);
        calm    = (sent > CALM_AFTER);
        if ($urandom_range(0, 3) == 0)
            send_item(make_item(KIND_CLEAR, $urandom_range(0, 4095), 1'($urandom_range(0, 1))));
        n_asm = $urandom_range(0, 6);
        repeat (n_asm)
            send_item(make_item(KIND_ASSUME, pick_lit(nv), 1'($urandom_range(0, 1))));
        n_cl = $urandom_range(1, 8);
        for (int c = 0; c < n_cl; c++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                // slip in an assumption change mid-clause now and then
                if ($urandom_range(0, 39) == 0)
                    send_item(make_item(($urandom_range(0, 3) == 0) ? KIND_CLEAR : KIND_ASSUME,
                                        pick_lit(nv), 1'($urandom_range(0, 1))));
                close_it = (i == len - 1) && ($urandom_range(0, 19) != 0);
                send_item(make_item(KIND_CLAUSE, pick_lit(nv), close_it));
            end
        end
        send_item(make_item(KIND_EOF, $urandom_range(0, 4095), 1'($urandom_range(0, 1))));
    endtask

    initial
    begin
        int unsigned n_form;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain clause with nothing assumed.
        send_item(make_item(KIND_CLAUSE, 1, 1'b0));
        send_item(make_item(KIND_CLAUSE, -2, 1'b1));
        // Assumptions, including the range edges and ignored ones.
        send_item(make_item(KIND_ASSUME, 1, 1'b0));
        send_item(make_item(KIND_ASSUME, -3, 1'b1));
        send_item(make_item(KIND_ASSUME, 1024, 1'b0));
        send_item(make_item(KIND_ASSUME, -1024, 1'b0));
        send_item(make_item(KIND_ASSUME, 0, 1'b0));
        send_item(make_item(KIND_ASSUME, 2047, 1'b0));
        send_item(make_item(KIND_ASSUME, -2048, 1'b0));
        // Every literal removed: empty clause.
        send_item(make_item(KIND_CLAUSE, -1, 1'b0));
        send_item(make_item(KIND_CLAUSE, 3, 1'b1));
        // Satisfied clause; the literal after it is ignored.
        send_item(make_item(KIND_CLAUSE, 5, 1'b0));
        send_item(make_item(KIND_CLAUSE, 1, 1'b0));
        send_item(make_item(KIND_CLAUSE, -7, 1'b1));
        // Zero literal alone closes an empty clause after unsat.
        send_item(make_item(KIND_CLAUSE, 0, 1'b1));
        // Out-of-range literals pass unchanged.
        send_item(make_item(KIND_CLAUSE, 2047, 1'b0));
        send_item(make_item(KIND_CLAUSE, -2048, 1'b1));
        // Both polarities of variable 1 assumed.
        send_item(make_item(KIND_ASSUME, -1, 1'b0));
        send_item(make_item(KIND_CLAUSE, -1, 1'b1));
        send_item(make_item(KIND_EOF, 0, 1'b0));
        send_item(make_item(KIND_EOF, 0, 1'b1));
        send_item(make_item(KIND_CLEAR, 0, 1'b0));
        send_item(make_item(KIND_CLAUSE, 1, 1'b1));
        // Unterminated clause dropped at end of formula.
        send_item(make_item(KIND_CLAUSE, 4, 1'b0));
        send_item(make_item(KIND_EOF, 0, 1'b0));
        drain_results();

        n_form = 0;
        while (sent < ITEM_GOAL)
        begin
            random_formula();
            n_form++;
            if (n_form == 3)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
